[sv/pba_pkg.sv]
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and constants of the page block allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

	localparam int ADDR_W              = 48;
	localparam int SIZE_W              = 32;
	localparam int STATUS_W            = 3;
	localparam int PAGE_LSB_W          = 12;
	localparam int DEFAULT_TABLE_DEPTH = 256;

	localparam logic [ADDR_W-1:0] PAGE_BYTES = ADDR_W'(4096);

	// operation codes
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_BAD_SIZE    = 3'd1,
		ST_FULL        = 3'd2,
		ST_UNKNOWN_PTR = 3'd3,
		ST_OVERFLOW    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_APPEND
	} state_t;

	// write controls toward the record table
	typedef struct packed {
		logic start_we;
		logic used_we;
		logic used_val;
	} tbl_wr_t;

endpackage

[sv/pba_gap_unit.sv]
// ----------------------------------------------------------------------------
// pba_gap_unit
// Shared adder and compare: block start plus request size against a limit.
// ----------------------------------------------------------------------------
module pba_gap_unit (
	input  logic [pba_pkg::ADDR_W-1:0] base,
	input  logic [pba_pkg::SIZE_W-1:0] size,
	input  logic [pba_pkg::ADDR_W-1:0] limit,
	output logic [pba_pkg::ADDR_W-1:0] sum,
	output logic                       carry,
	output logic                       fits
);
	import pba_pkg::*;

	logic [ADDR_W:0] sum_full;

	// one wide add, one compare
	assign sum_full = {1'b0, base} + (ADDR_W + 1)'(size);
	assign sum      = sum_full[ADDR_W-1:0];
	assign carry    = sum_full[ADDR_W];
	assign fits     = (sum_full <= {1'b0, limit});

endmodule

[sv/pba_table.sv]
// ----------------------------------------------------------------------------
// pba_table
// Block record memories: start address and used mark, one write port and
// one registered read port.
// ----------------------------------------------------------------------------
module pba_table #(
	parameter int DEPTH = pba_pkg::DEFAULT_TABLE_DEPTH,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  pba_pkg::tbl_wr_t           wr,
	input  logic [IDX_W-1:0]           wr_addr,
	input  logic [pba_pkg::ADDR_W-1:0] wr_start,
	input  logic                       rd_en,
	input  logic [IDX_W-1:0]           rd_addr,
	output logic [pba_pkg::ADDR_W-1:0] rd_start,
	output logic                       rd_used
);
	import pba_pkg::*;

	logic [ADDR_W-1:0] start_mem [DEPTH];
	logic              used_mem  [DEPTH];
	logic [ADDR_W-1:0] rd_start_q;
	logic              rd_used_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr.start_we) begin
			start_mem[wr_addr] <= wr_start;
		end
		if (wr.used_we) begin
			used_mem[wr_addr] <= wr.used_val;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_start_q <= start_mem[rd_addr];
			rd_used_q  <= used_mem[rd_addr];
		end
	end

	assign rd_start = rd_start_q;
	assign rd_used  = rd_used_q;

endmodule

[sv/page_block_allocator.sv]
// ----------------------------------------------------------------------------
// page_block_allocator
// First-fit page allocator over a table of block records.
// ----------------------------------------------------------------------------
// bad size answers in the cycle after start; allocate and free scan the
//   records, the table read port giving one record a cycle
// throughput: one request at a time, busy stays high from an accepted allocate or free until the result strobe
// results are shown for one cycle on done; the receiver cannot stall
// reset: record count 0, next address one page above a heap base of 0
// a heap_base write reinitializes record count and next address
module page_block_allocator #(
	parameter int TABLE_DEPTH = pba_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [pba_pkg::ADDR_W-1:0]   cfg_wdata,
	input  logic                         start,
	output logic                         busy,
	input  logic                         func,
	input  logic [pba_pkg::SIZE_W-1:0]   size_bytes,
	input  logic [pba_pkg::ADDR_W-1:0]   address,
	output logic                         done,
	output logic [pba_pkg::ADDR_W-1:0]   address_res,
	output logic [pba_pkg::STATUS_W-1:0] status
);
	import pba_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [ADDR_W-1:0] next_address_q, next_address_d;
	logic [CNT_W-1:0]  ridx_q, ridx_d;
	logic              rvalid_s1, rvalid_d;
	logic [IDX_W-1:0]  ridx_s1;
	logic              hold_valid_q, hold_valid_d;
	logic [ADDR_W-1:0] hold_start_q, hold_start_d;
	logic              hold_used_q, hold_used_d;
	logic [IDX_W-1:0]  hold_idx_q, hold_idx_d;
	logic              done_q, done_d;
	logic [ADDR_W-1:0] address_res_q, address_res_d;
	status_t           status_q, status_d;
	logic              func_q;
	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] addr_q;

	tbl_wr_t           wr;
	logic [IDX_W-1:0]  wr_addr;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_start;
	logic              rd_used;
	logic              issue;
	logic              bad_size;
	logic              last_ok;

	logic [ADDR_W-1:0] unit_base;
	logic [ADDR_W-1:0] unit_limit;
	logic [ADDR_W-1:0] unit_sum;
	logic              unit_carry;
	logic              unit_fits;

	pba_table #(
		.DEPTH (TABLE_DEPTH),
		.IDX_W (IDX_W)
	) u_table (
		.clk      (clk),
		.wr       (wr),
		.wr_addr  (wr_addr),
		.wr_start (next_address_q),
		.rd_en    (rd_en),
		.rd_addr  (ridx_q[IDX_W-1:0]),
		.rd_start (rd_start),
		.rd_used  (rd_used)
	);

	pba_gap_unit u_gap (
		.base  (unit_base),
		.size  (size_q),
		.limit (unit_limit),
		.sum   (unit_sum),
		.carry (unit_carry),
		.fits  (unit_fits)
	);

	assign bad_size = (size_bytes == '0) || (size_bytes[PAGE_LSB_W-1:0] != '0);
	assign issue    = (state_q == S_SCAN) && (ridx_q < count_q);
	assign last_ok  = rvalid_s1 || (size_q == SIZE_W'(PAGE_BYTES));

	// sequencer: next state, table access and result
	always_comb begin
		state_d        = state_q;
		count_d        = count_q;
		next_address_d = next_address_q;
		ridx_d         = ridx_q;
		rvalid_d       = 1'b0;
		hold_valid_d   = hold_valid_q;
		hold_start_d   = hold_start_q;
		hold_used_d    = hold_used_q;
		hold_idx_d     = hold_idx_q;
		done_d         = 1'b0;
		address_res_d  = address_res_q;
		status_d       = status_q;
		wr             = '0;
		wr_addr        = hold_idx_q;
		rd_en          = 1'b0;
		unit_base      = hold_start_q;
		unit_limit     = next_address_q;

		unique case (state_q)
			S_IDLE: begin
				ridx_d       = '0;
				hold_valid_d = 1'b0;
				if (start) begin
					if (func == FUNC_ALLOC && bad_size) begin
						done_d        = 1'b1;
						address_res_d = '0;
						status_d      = ST_BAD_SIZE;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				// stream the records out one a cycle
				rd_en    = issue;
				rvalid_d = issue;
				if (issue) begin
					ridx_d = ridx_q + 1'b1;
				end
				if (func_q == FUNC_FREE) begin
					// free: first record with a matching start
					if (rvalid_s1 && rd_start == addr_q) begin
						wr.used_we    = 1'b1;
						wr.used_val   = 1'b0;
						wr_addr       = ridx_s1;
						done_d        = 1'b1;
						address_res_d = '0;
						status_d      = ST_OK;
						state_d       = S_IDLE;
					end else if (!issue && !rvalid_s1) begin
						done_d        = 1'b1;
						address_res_d = '0;
						status_d      = ST_UNKNOWN_PTR;
						state_d       = S_IDLE;
					end
				end else begin
					// held record gap runs to the next start, or to next address
					if (rvalid_s1) begin
						unit_limit = rd_start;
					end
					if (hold_valid_q && !hold_used_q && unit_fits && last_ok) begin
						wr.used_we    = 1'b1;
						wr.used_val   = 1'b1;
						wr_addr       = hold_idx_q;
						done_d        = 1'b1;
						address_res_d = hold_start_q;
						status_d      = ST_OK;
						state_d       = S_IDLE;
					end else if (rvalid_s1) begin
						hold_valid_d = 1'b1;
						hold_start_d = rd_start;
						hold_used_d  = rd_used;
						hold_idx_d   = ridx_s1;
					end else if (!issue) begin
						state_d = S_APPEND;
					end
				end
			end
			S_APPEND: begin
				// new record at next address
				unit_base = next_address_q;
				done_d    = 1'b1;
				state_d   = S_IDLE;
				if (count_q == CNT_W'(TABLE_DEPTH)) begin
					address_res_d = '0;
					status_d      = ST_FULL;
				end else if (unit_carry) begin
					address_res_d = '0;
					status_d      = ST_OVERFLOW;
				end else begin
					wr.start_we    = 1'b1;
					wr.used_we     = 1'b1;
					wr.used_val    = 1'b1;
					wr_addr        = count_q[IDX_W-1:0];
					count_d        = count_q + 1'b1;
					next_address_d = unit_sum;
					address_res_d  = next_address_q;
					status_d       = ST_OK;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// heap base write reinitializes record count and next address
		if (cfg_we) begin
			count_d        = '0;
			next_address_d = cfg_wdata + PAGE_BYTES;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			count_q        <= '0;
			next_address_q <= PAGE_BYTES;
			ridx_q         <= '0;
			rvalid_s1      <= 1'b0;
			hold_valid_q   <= 1'b0;
			done_q         <= 1'b0;
		end else begin
			state_q        <= state_d;
			count_q        <= count_d;
			next_address_q <= next_address_d;
			ridx_q         <= ridx_d;
			rvalid_s1      <= rvalid_d;
			hold_valid_q   <= hold_valid_d;
			done_q         <= done_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		ridx_s1       <= ridx_q[IDX_W-1:0];
		hold_start_q  <= hold_start_d;
		hold_used_q   <= hold_used_d;
		hold_idx_q    <= hold_idx_d;
		address_res_q <= address_res_d;
		status_q      <= status_d;
		if (start && !busy) begin
			func_q <= func;
			size_q <= size_bytes;
			addr_q <= address;
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign address_res = address_res_q;
	assign status      = status_q;

	// checks
	a_err_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> address_res == '0)
		else $error("nonzero address with error status");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("record count beyond table depth");

	a_ridx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> ridx_q <= count_q)
		else $error("read index past record count");

	a_bad_size: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && func == FUNC_ALLOC && size_bytes == '0
		|=> done && status == ST_BAD_SIZE)
		else $error("zero size not rejected");

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives allocate and free requests into the page block allocator and
// predicts every answer with its own copy of the record table and next free
// address. Covers bad sizes, first fit, last record reuse,
// double and unknown frees, table full and address overflow over several
// heap base settings.
// ----------------------------------------------------------------------------
module testbench;
	import pba_pkg::*;

	localparam int DEPTH       = DEFAULT_TABLE_DEPTH;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		status_t           st;
	} answer_t;

	// shadow copy of the allocator plus the queue of awaited answers
	class page_table_tracker;
		logic [ADDR_W-1:0] rec_start [DEFAULT_TABLE_DEPTH];
		bit                rec_used  [DEFAULT_TABLE_DEPTH];
		int unsigned       rec_total;
		logic [ADDR_W-1:0] next_free;
		answer_t           awaited_answers [$];
		int unsigned       mismatches;

		function new();
			mismatches = 0;
			set_heap_base('0);
		endfunction

		// a heap base write restarts the table
		function void set_heap_base(input logic [ADDR_W-1:0] base);
			rec_total = 0;
			next_free = base + PAGE_BYTES;
		endfunction

		// gap of a record runs to the next record, or to next_free for the last
		function bit gap_holds(input int unsigned idx, input logic [ADDR_W:0] span);
			logic [ADDR_W:0] limit;
			if (idx + 1 >= rec_total) begin
				if (span > {1'b0, PAGE_BYTES})
					return 1'b0;
				limit = {1'b0, next_free};
			end else begin
				limit = {1'b0, rec_start[idx+1]};
			end
			return ({1'b0, rec_start[idx]} + span) <= limit;
		endfunction

		function answer_t predict_answer(input logic f, input logic [SIZE_W-1:0] sz,
				input logic [ADDR_W-1:0] a);
			answer_t         ans;
			logic [ADDR_W:0] span;
			logic [ADDR_W:0] end_addr;
			int unsigned     i;
			ans.addr = '0;
			ans.st   = ST_OK;
			// free: first record with a matching start
			if (f == FUNC_FREE) begin
				for (i = 0; i < rec_total; i++) begin
					if (rec_start[i] == a) begin
						rec_used[i] = 1'b0;
						return ans;
					end
				end
				ans.st = ST_UNKNOWN_PTR;
				return ans;
			end
			// allocate: size check, first fit, then append
			if (sz == '0 || sz[PAGE_LSB_W-1:0] != '0) begin
				ans.st = ST_BAD_SIZE;
				return ans;
			end
			span = (ADDR_W+1)'(sz);
			for (i = 0; i < rec_total; i++) begin
				if (!rec_used[i] && gap_holds(i, span)) begin
					rec_used[i] = 1'b1;
					ans.addr    = rec_start[i];
					return ans;
				end
			end
			if (rec_total >= DEFAULT_TABLE_DEPTH) begin
				ans.st = ST_FULL;
				return ans;
			end
			end_addr = {1'b0, next_free} + span;
			if (end_addr[ADDR_W]) begin
				ans.st = ST_OVERFLOW;
				return ans;
			end
			rec_start[rec_total] = next_free;
			rec_used[rec_total]  = 1'b1;
			rec_total++;
			ans.addr  = next_free;
			next_free = end_addr[ADDR_W-1:0];
			return ans;
		endfunction

		function void note_request(input logic f, input logic [SIZE_W-1:0] sz,
				input logic [ADDR_W-1:0] a);
			awaited_answers.push_back(predict_answer(f, sz, a));
		endfunction

		function void check_answer(input logic [ADDR_W-1:0] got_addr,
				input logic [STATUS_W-1:0] got_st);
			answer_t exp;
			if (awaited_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: result addr %h status %0d with none awaited",
						got_addr, got_st);
				return;
			end
			exp = awaited_answers.pop_front();
			if (got_addr !== exp.addr || got_st !== exp.st) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected addr %h status %0d, got addr %h status %0d",
						exp.addr, exp.st, got_addr, got_st);
			end
		endfunction
	endclass

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                cfg_we     = 1'b0;
	logic [ADDR_W-1:0]   cfg_wdata  = '0;
	logic                start      = 1'b0;
	logic                func       = FUNC_ALLOC;
	logic [SIZE_W-1:0]   size_bytes = '0;
	logic [ADDR_W-1:0]   address    = '0;
	logic                busy;
	logic                done;
	logic [ADDR_W-1:0]   address_res;
	logic [STATUS_W-1:0] status;

	page_table_tracker tracker = new();
	bit                gaps_on;
	int unsigned       stall_cycles = 0;

	page_block_allocator #(
		.TABLE_DEPTH(DEPTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.size_bytes (size_bytes),
		.address    (address),
		.done       (done),
		.address_res(address_res),
		.status     (status)
	);

	// clock
	always #1 clk = ~clk;

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_answer(address_res, status);
	end

	// watchdog on cycles without any request or result
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic logic [ADDR_W-1:0] any_address();
		return {16'($urandom_range(0, 65535)), 32'($urandom)};
	endfunction

	// mostly small page counts, now and then a huge one
	function automatic logic [SIZE_W-1:0] rand_alloc_bytes();
		int         pick;
		logic [19:0] pages;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			pages = 20'd1;
		else if (pick < 85)
			pages = 20'($urandom_range(2, 8));
		else if (pick < 95)
			pages = 20'($urandom_range(9, 256));
		else
			pages = 20'($urandom_range(1, 20'hFFFFF));
		return {pages, 12'h000};
	endfunction

	// present one request and hold it until accepted
	task automatic send(input logic f, input logic [SIZE_W-1:0] sz,
			input logic [ADDR_W-1:0] a);
		start      <= 1'b1;
		func       <= f;
		size_bytes <= sz;
		address    <= a;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		tracker.note_request(f, sz, a);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (tracker.awaited_answers.size() != 0)
			@(posedge clk);
	endtask

	// random gap after an accepted request, now and then a full drain
	task automatic maybe_pause();
		if (!gaps_on)
			return;
		if ($urandom_range(0, 63) == 0) begin
			wait_drained();
		end else if ($urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4))
				@(posedge clk);
		end
	endtask

	// heap base write once the allocator is idle
	task automatic load_heap_base(input logic [ADDR_W-1:0] base);
		wait_drained();
		repeat (8)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= base;
		@(posedge clk);
		cfg_we    <= 1'b0;
		tracker.set_heap_base(base);
	endtask

	task automatic send_paced(input logic f, input logic [SIZE_W-1:0] sz,
			input logic [ADDR_W-1:0] a);
		send(f, sz, a);
		maybe_pause();
	endtask

	// random requests: well-formed allocs and frees, plus noise
	task automatic run_mix(input int count, input int alloc_pct, input int free_pct,
			input bit gaps_allowed);
		int          pick;
		int unsigned k;
		for (k = 0; k < count; k++) begin
			if (k % 40 == 0)
				gaps_on = gaps_allowed && ($urandom_range(0, 2) != 0);
			pick = $urandom_range(0, 99);
			if (pick < alloc_pct)
				send_paced(FUNC_ALLOC, rand_alloc_bytes(), any_address());
			else if (pick < alloc_pct + free_pct && tracker.rec_total > 0)
				send_paced(FUNC_FREE, $urandom,
					tracker.rec_start[$urandom_range(0, tracker.rec_total - 1)]);
			else if ($urandom_range(0, 1) == 0)
				send_paced(FUNC_ALLOC, ($urandom_range(0, 7) == 0) ? '0 : $urandom,
					any_address());
			else
				send_paced(FUNC_FREE, $urandom, any_address());
		end
	endtask

	initial begin
		gaps_on = 1'b1;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset heap base of zero
		send_paced(FUNC_FREE, '0, '0);
		send_paced(FUNC_ALLOC, '0, 48'hFFFF_FFFF_FFFF);
		send_paced(FUNC_ALLOC, 32'hFFFF_FFFF, '0);
		send_paced(FUNC_ALLOC, 32'h0000_0FFF, '0);
		send_paced(FUNC_ALLOC, 32'h0000_1001, '0);
		send_paced(FUNC_ALLOC, 32'h0000_1000, '0);
		send_paced(FUNC_ALLOC, 32'h0000_3000, '0);
		send_paced(FUNC_ALLOC, 32'hFFFF_F000, '0);
		send_paced(FUNC_FREE, 32'hFFFF_FFFF, 48'h0000_0000_2000);
		// double free
		send_paced(FUNC_FREE, '0, 48'h0000_0000_2000);
		// first fit into the freed gap
		send_paced(FUNC_ALLOC, 32'h0000_1000, '0);
		send_paced(FUNC_FREE, '0, tracker.rec_start[tracker.rec_total-1]);
		// last record refuses more than one page
		send_paced(FUNC_ALLOC, 32'h0000_2000, '0);
		send_paced(FUNC_FREE, '0, tracker.rec_start[tracker.rec_total-1]);
		// last record reused for one page
		send_paced(FUNC_ALLOC, 32'h0000_1000, '0);
		send_paced(FUNC_FREE, '0, 48'hFFFF_FFFF_FFFF);
		send_paced(FUNC_FREE, '0, 48'h0000_0000_1001);
		run_mix(150, 55, 30, 1'b1);

		// random heap base
		load_heap_base(any_address());
		run_mix(350, 55, 30, 1'b1);

		// lowest heap base, alloc heavy to fill the table
		load_heap_base('0);
		run_mix(400, 85, 5, 1'b1);

		// near the top of the address space: overflow edges
		load_heap_base(48'hFFFF_FFF0_0000);
		send_paced(FUNC_ALLOC, 32'hFFFF_F000, '0);
		send_paced(FUNC_ALLOC, 32'h0010_0000, '0);
		send_paced(FUNC_ALLOC, 32'h000F_F000, '0);
		send_paced(FUNC_ALLOC, 32'h000F_E000, '0);
		send_paced(FUNC_ALLOC, 32'h0000_1000, '0);
		send_paced(FUNC_FREE, '0, tracker.rec_start[tracker.rec_total-1]);
		send_paced(FUNC_ALLOC, 32'h0000_1000, '0);
		run_mix(240, 55, 30, 1'b1);

		// highest heap base, next address wraps; no gaps to the end
		load_heap_base(48'hFFFF_FFFF_FFFF);
		run_mix(300, 55, 30, 1'b0);

		// drain and let any stray result show up
		wait_drained();
		repeat (DEPTH + 8)
			@(posedge clk);
		if (tracker.mismatches == 0 && tracker.awaited_answers.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
